@@ sv/gsa_pkg.sv @@
`default_nettype none

package gsa_pkg;

    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 6;
    localparam int HGEN_W   = 16;

    localparam logic [MODE_W-1:0] MODE_ACQUIRE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PAUSE   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RESUME  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_POOL_FULL = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [INDEX_W-1:0] slot_index;
        logic [HGEN_W-1:0]  handle_generation;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  out_index;
        logic [HGEN_W-1:0]   out_generation;
        logic                is_paused;
    } rsp_t;

endpackage

`default_nettype wire

@@ sv/gsa_ram.sv @@
`default_nettype none

module gsa_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/generational_slot_allocator.sv @@
// Generational slot allocator: a pool of NUM_SLOTS slots reached through
// handles made of a slot index and a generation.
// Request channel (req_valid / req_stall / req): one transaction carries an
// operation (acquire, release, pause, resume, query) and a handle.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one transaction
// per request, in order: status, slot index, generation, paused mark.
// A request is registered on acceptance and its response in the execute
// step; an acquire served from the free stack first passes a stack step,
// since the stack memory read must return the index before the slot memory
// can be read. The slot memory read-modify-write allows one request at a time.
// req_stall is high while a request is in progress. A stalled response is
// held in the output register; the next request is accepted meanwhile and
// completes once that response has been taken.
// Reset clears all slot state at once: an entry at or above the count of
// slots ever handed out reads as zero, so no clearing pass is needed.
`default_nettype none

module generational_slot_allocator #(
    parameter int NUM_SLOTS = 64,
    parameter int GEN_BITS  = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire gsa_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output gsa_pkg::rsp_t      rsp
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int CNT_W = $clog2(NUM_SLOTS + 1);
    localparam int ENT_W = GEN_BITS + 2;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_SLOTS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_STACK = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [gsa_pkg::MODE_W-1:0]  mode_reg;
    logic [gsa_pkg::INDEX_W-1:0] idx_reg;
    logic [gsa_pkg::HGEN_W-1:0]  hgen_reg;
    logic                        inrange_reg;
    logic [IDX_W-1:0]            sel_reg;

    logic [CNT_W-1:0] free_count_reg, free_count_next;
    logic [CNT_W-1:0] used_count_reg, used_count_next;

    logic          rsp_valid_reg, rsp_valid_next;
    gsa_pkg::rsp_t rsp_reg, rsp_next;

    logic             slot_we;
    logic [IDX_W-1:0] slot_waddr, slot_raddr;
    logic [ENT_W-1:0] slot_wdata, slot_rdata;

    logic             stk_we;
    logic [IDX_W-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

    logic                accept, exec_go, pop_sel;
    logic [IDX_W-1:0]    req_addr;
    logic                req_inrange;
    logic                slot_ok, hit;
    logic [ENT_W-1:0]    ent;
    logic                ent_act, ent_pz;
    logic [GEN_BITS-1:0] ent_gen, new_gen;
    gsa_pkg::rsp_t       res;
    logic                wr_slot, do_pop, do_fresh, do_push;
    logic [ENT_W-1:0]    wr_ent;

    gsa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    gsa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_SLOTS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign req_stall   = (state_reg != ST_IDLE);
    assign accept      = req_valid && (state_reg == ST_IDLE);
    assign exec_go     = (state_reg == ST_EXEC) && (!rsp_valid_reg || !rsp_stall);
    assign req_addr    = IDX_W'(req.slot_index);
    assign req_inrange = 32'(req.slot_index) < NUM_SLOTS;
    assign pop_sel     = (req.mode == gsa_pkg::MODE_ACQUIRE) && (free_count_reg != '0);

    assign stk_raddr  = IDX_W'(free_count_reg - CNT_W'(1));
    assign slot_raddr = (state_reg == ST_STACK) ? stk_rdata :
                        (state_reg == ST_EXEC) ? sel_reg :
                        (req.mode == gsa_pkg::MODE_ACQUIRE) ? IDX_W'(used_count_reg) :
                        req_addr;

    // entries never handed out since reset read as zero
    assign slot_ok = CNT_W'(sel_reg) < used_count_reg;
    assign ent     = slot_ok ? slot_rdata : '0;
    assign ent_act = ent[ENT_W-1];
    assign ent_pz  = ent[ENT_W-2];
    assign ent_gen = ent[GEN_BITS-1:0];
    assign new_gen = ent_gen + GEN_BITS'(1);
    assign hit     = inrange_reg && ent_act && (32'(ent_gen) == 32'(hgen_reg));

    always_comb
    begin
        res.status         = gsa_pkg::STATUS_INVALID;
        res.out_index      = idx_reg;
        res.out_generation = '0;
        res.is_paused      = 1'b0;
        wr_slot            = 1'b0;
        wr_ent             = ent;
        do_pop             = 1'b0;
        do_fresh           = 1'b0;
        do_push            = 1'b0;

        unique case (mode_reg)
            gsa_pkg::MODE_ACQUIRE:
            begin
                if ((free_count_reg != '0) || (used_count_reg != CNT_FULL))
                begin
                    res.status         = gsa_pkg::STATUS_OK;
                    res.out_index      = gsa_pkg::INDEX_W'(sel_reg);
                    res.out_generation = gsa_pkg::HGEN_W'(ent_gen);
                    wr_slot            = 1'b1;
                    wr_ent             = {1'b1, 1'b0, ent_gen};
                    do_pop             = (free_count_reg != '0);
                    do_fresh           = (free_count_reg == '0);
                end
                else
                begin
                    res.status    = gsa_pkg::STATUS_POOL_FULL;
                    res.out_index = '0;
                end
            end
            gsa_pkg::MODE_RELEASE, gsa_pkg::MODE_PAUSE,
            gsa_pkg::MODE_RESUME, gsa_pkg::MODE_QUERY:
            begin
                res.out_generation = inrange_reg ? gsa_pkg::HGEN_W'(ent_gen) : '0;
                if (hit)
                begin
                    res.status    = gsa_pkg::STATUS_OK;
                    res.is_paused = ent_pz;
                    if (mode_reg == gsa_pkg::MODE_RELEASE)
                    begin
                        res.out_generation = gsa_pkg::HGEN_W'(new_gen);
                        res.is_paused      = 1'b0;
                        wr_slot            = 1'b1;
                        wr_ent             = {1'b0, 1'b0, new_gen};
                        do_push            = (free_count_reg != CNT_FULL);
                    end
                    else if (mode_reg == gsa_pkg::MODE_PAUSE)
                    begin
                        res.is_paused = 1'b1;
                        wr_slot       = 1'b1;
                        wr_ent        = {ent_act, 1'b1, ent_gen};
                    end
                    else if (mode_reg == gsa_pkg::MODE_RESUME)
                    begin
                        res.is_paused = 1'b0;
                        wr_slot       = 1'b1;
                        wr_ent        = {ent_act, 1'b0, ent_gen};
                    end
                end
            end
            default:
            begin
                res.status = gsa_pkg::STATUS_INVALID;
            end
        endcase
    end

    assign slot_we    = exec_go && wr_slot;
    assign slot_waddr = sel_reg;
    assign slot_wdata = wr_ent;
    assign stk_we     = exec_go && do_push;
    assign stk_waddr  = IDX_W'(free_count_reg);
    assign stk_wdata  = sel_reg;

    always_comb
    begin
        state_next      = state_reg;
        free_count_next = free_count_reg;
        used_count_next = used_count_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = pop_sel ? ST_STACK : ST_EXEC;
                end
            end
            ST_STACK:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next     = ST_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_next       = res;
                    if (do_pop)
                    begin
                        free_count_next = free_count_reg - CNT_W'(1);
                    end
                    if (do_push)
                    begin
                        free_count_next = free_count_reg + CNT_W'(1);
                    end
                    if (do_fresh)
                    begin
                        used_count_next = used_count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_count_reg <= '0;
            used_count_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            used_count_reg <= used_count_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            mode_reg    <= req.mode;
            idx_reg     <= req.slot_index;
            hgen_reg    <= req.handle_generation;
            inrange_reg <= req_inrange;
            sel_reg     <= (req.mode == gsa_pkg::MODE_ACQUIRE) ? IDX_W'(used_count_reg) :
                           req_addr;
        end
        else if (state_reg == ST_STACK)
        begin
            sel_reg <= stk_rdata;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_free_within_used: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= used_count_reg)
        else $error("free stack holds more slots than were ever handed out");

    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == ST_EXEC)
        else $error("response raised outside the execute step");

    a_full_means_exhausted: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go && (res.status == gsa_pkg::STATUS_POOL_FULL)
        |-> (free_count_reg == '0) && (used_count_reg == CNT_FULL))
        else $error("pool full reported while slots remain");

endmodule

`default_nettype wire
